>>> sv/ffbp_pkg.sv
// ffbp_pkg: shared widths, reset values, codes and payload structs
// for the first-fit bin packer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffbp_pkg;

   localparam int MAX_BINS_DEF = 64;

   localparam int CID_W   = 16;
   localparam int REC_W   = 16;
   localparam int RB_W    = 16;
   localparam int CAP_W   = 32;
   localparam int DEM_W   = 32;
   localparam int BIDX_W  = 6;
   localparam int BOPEN_W = 7;
   localparam int STAT_W  = 2;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_BIN_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_BYTES = 1'd1;

   localparam logic [CAP_W-1:0] CAP_RESET = 32'd1048576;
   localparam logic [RB_W-1:0]  RB_RESET  = 16'd64;

   localparam logic [STAT_W-1:0] ST_PLACED   = 2'd0;
   localparam logic [STAT_W-1:0] ST_OVERSIZE = 2'd1;
   localparam logic [STAT_W-1:0] ST_REJECTED = 2'd2;

   // classified item handed from front to back
   typedef struct packed {
      logic [CID_W-1:0] cid;
      logic [DEM_W-1:0] demand;
      logic             oversize;
   } job_type;

   typedef struct packed {
      logic [CID_W-1:0]   cid;
      logic [BIDX_W-1:0]  bin_index;
      logic [BOPEN_W-1:0] bins_open;
      logic [STAT_W-1:0]  status;
   } rsp_type;

endpackage
`default_nettype wire

>>> sv/ffbp_fifo.sv
// ffbp_fifo: small register queue, power-of-two depth.
// Uses no package items; used between front, back and the result port.
`timescale 1ns / 1ps
`default_nettype none
module ffbp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      dout,
   output logic                  empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule
`default_nettype wire

>>> sv/ffbp_front.sv
// ffbp_front: config registers, item intake, demand multiply and
// oversize classification. Depends on ffbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffbp_front
   import ffbp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [CID_W-1:0]      req_cluster_id,
   input  wire logic [REC_W-1:0]      req_record_count,
   output logic                       job_push,
   output job_type                    job_data,
   input  wire logic                  job_full,
   output logic [CAP_W-1:0]           bin_capacity
);
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [RB_W-1:0]  rbytes_ff, rbytes_in;
   logic             stage_valid_ff, stage_valid_in;
   logic [CID_W-1:0] stage_cid_ff, stage_cid_in;
   logic [DEM_W-1:0] stage_demand_ff, stage_demand_in;
   logic             accept, advance;

   assign bin_capacity = cap_ff;
   assign advance      = stage_valid_ff && !job_full;
   assign req_full     = stage_valid_ff && job_full;
   assign accept       = req_push && !req_full;

   assign job_push        = advance;
   assign job_data.cid    = stage_cid_ff;
   assign job_data.demand = stage_demand_ff;
   // oversize items skip the scan in the back end
   assign job_data.oversize = (stage_demand_ff > cap_ff);

   always_comb begin
      cap_in    = cap_ff;
      rbytes_in = rbytes_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BIN_CAPACITY: cap_in    = csr_wdata[CAP_W-1:0];
            CSR_RECORD_BYTES: rbytes_in = csr_wdata[RB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      stage_valid_in  = stage_valid_ff;
      stage_cid_in    = stage_cid_ff;
      stage_demand_in = stage_demand_ff;
      if (accept) begin
         stage_valid_in  = 1'b1;
         stage_cid_in    = req_cluster_id;
         stage_demand_in = DEM_W'(req_record_count * rbytes_ff);
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff         <= CAP_RESET;
         rbytes_ff      <= RB_RESET;
         stage_valid_ff <= 1'b0;
      end else begin
         cap_ff         <= cap_in;
         rbytes_ff      <= rbytes_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_cid_ff    <= stage_cid_in;
      stage_demand_ff <= stage_demand_in;
   end

endmodule
`default_nettype wire

>>> sv/ffbp_back.sv
// ffbp_back: bin usage memory and first-fit scan sequencer, one bin per
// cycle through a registered read port. Depends on ffbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffbp_back
   import ffbp_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CAP_W-1:0] bin_capacity,
   input  wire logic             job_empty,
   input  wire job_type          job_data,
   output logic                  job_pop,
   input  wire logic             rsp_full,
   output logic                  rsp_push,
   output rsp_type               rsp_data
);
   localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int NUM_W = $clog2(MAX_BINS + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   job_type           job_ff, job_in;
   logic [NUM_W-1:0]  issue_ff, issue_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CAP_W-1:0]  rd_data_ff;
   logic [NUM_W-1:0]  open_ff, open_in;
   logic              bin0_wr_ff, bin0_wr_in;
   logic              dec_wr_ff, dec_wr_in;
   logic [IDX_W-1:0]  dec_addr_ff, dec_addr_in;
   logic [CAP_W-1:0]  dec_data_ff, dec_data_in;
   logic [STAT_W-1:0] dec_status_ff, dec_status_in;
   logic              dec_inc_ff, dec_inc_in;

   logic [CAP_W-1:0]  used_mem [MAX_BINS];
   logic              mem_we;
   logic [CAP_W-1:0]  used_val;
   logic [CAP_W:0]    fit_sum;
   logic              fit, issue_ok, room_left;
   logic [NUM_W-1:0]  open_next;
   logic [31:0]       addr_wide, open_wide;

   // bins at index 1 and up are written when opened; only bin 0 needs a flag
   assign used_val  = (rd_idx_ff == '0 && !bin0_wr_ff) ? '0 : rd_data_ff;
   assign fit_sum   = {1'b0, used_val} + {1'b0, job_ff.demand};
   assign fit       = (fit_sum <= {1'b0, bin_capacity});
   assign issue_ok  = (issue_ff < open_ff);
   assign room_left = (open_ff < NUM_W'(MAX_BINS));
   assign open_next = dec_inc_ff ? open_ff + 1'b1 : open_ff;
   assign addr_wide = 32'(dec_addr_ff);
   assign open_wide = 32'(open_next);

   assign rsp_data.cid       = job_ff.cid;
   assign rsp_data.bin_index = addr_wide[BIDX_W-1:0];
   assign rsp_data.bins_open = open_wide[BOPEN_W-1:0];
   assign rsp_data.status    = dec_status_ff;

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      issue_in      = issue_ff;
      rd_pend_in    = rd_pend_ff;
      rd_idx_in     = rd_idx_ff;
      open_in       = open_ff;
      bin0_wr_in    = bin0_wr_ff;
      dec_wr_in     = dec_wr_ff;
      dec_addr_in   = dec_addr_ff;
      dec_data_in   = dec_data_ff;
      dec_status_in = dec_status_ff;
      dec_inc_in    = dec_inc_ff;
      job_pop       = 1'b0;
      rsp_push      = 1'b0;
      mem_we        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               job_pop    = 1'b1;
               job_in     = job_data;
               issue_in   = '0;
               rd_pend_in = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!job_ff.oversize && rd_pend_ff && fit) begin
               dec_wr_in     = 1'b1;
               dec_addr_in   = rd_idx_ff;
               dec_data_in   = fit_sum[CAP_W-1:0];
               dec_status_in = ST_PLACED;
               dec_inc_in    = 1'b0;
               state_in      = S_DONE;
            end else if (job_ff.oversize || (!rd_pend_ff && !issue_ok)) begin
               // no open bin fits, or the item is oversize: open the next one if any is left
               state_in = S_DONE;
               if (room_left) begin
                  dec_wr_in     = 1'b1;
                  dec_addr_in   = open_ff[IDX_W-1:0];
                  dec_data_in   = job_ff.oversize ? bin_capacity : job_ff.demand;
                  dec_status_in = job_ff.oversize ? ST_OVERSIZE : ST_PLACED;
                  dec_inc_in    = 1'b1;
               end else begin
                  dec_wr_in     = 1'b0;
                  dec_addr_in   = '0;
                  dec_status_in = ST_REJECTED;
                  dec_inc_in    = 1'b0;
               end
            end else begin
               rd_pend_in = issue_ok;
               rd_idx_in  = issue_ff[IDX_W-1:0];
               if (issue_ok) begin
                  issue_in = issue_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               mem_we   = dec_wr_ff;
               open_in  = open_next;
               if (dec_wr_ff && dec_addr_ff == '0) begin
                  bin0_wr_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rd_pend_ff <= 1'b0;
         open_ff    <= NUM_W'(1);
         bin0_wr_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
         open_ff    <= open_in;
         bin0_wr_ff <= bin0_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      issue_ff      <= issue_in;
      rd_idx_ff     <= rd_idx_in;
      dec_wr_ff     <= dec_wr_in;
      dec_addr_ff   <= dec_addr_in;
      dec_data_ff   <= dec_data_in;
      dec_status_ff <= dec_status_in;
      dec_inc_ff    <= dec_inc_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         used_mem[dec_addr_ff] <= dec_data_ff;
      end
      rd_data_ff <= used_mem[issue_ff[IDX_W-1:0]];
   end

   open_range_chk: assert property (@(posedge clock) disable iff (reset)
      open_ff != '0 && open_ff <= NUM_W'(MAX_BINS))
      else $error("open bin count out of range");

   scan_idx_chk: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN && rd_pend_ff |-> NUM_W'(rd_idx_ff) < open_ff)
      else $error("scan read beyond open bins");

   chosen_chk: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && dec_wr_ff |-> NUM_W'(dec_addr_ff) <= open_ff)
      else $error("chosen bin beyond next bin to open");

   reject_chk: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && dec_status_ff == ST_REJECTED
      |-> open_ff == NUM_W'(MAX_BINS) && !dec_wr_ff)
      else $error("rejection while bins remain");

endmodule
`default_nettype wire

>>> sv/first_fit_bin_packer_core.sv
// first_fit_bin_packer_core: top level; front end, job queue, scan back end
// and result queue. Depends on ffbp_pkg, ffbp_fifo, ffbp_front, ffbp_back.
// Scan: the back end handles one item at a time, pops no new job until the
// last result is pushed, and reads the bin usage memory through its single read port.
// Reset: synchronous; clears config to defaults, queues and one open bin;
// the usage memory needs no clearing pass (fill count plus a bin 0 flag).
`timescale 1ns / 1ps
`default_nettype none
module first_fit_bin_packer_core
   import ffbp_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [CID_W-1:0]      req_cluster_id,
   input  wire logic [REC_W-1:0]      req_record_count,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic [CID_W-1:0]           rsp_placed_cluster,
   output logic [BIDX_W-1:0]          rsp_bin_index,
   output logic [BOPEN_W-1:0]         rsp_bins_open,
   output logic [STAT_W-1:0]          rsp_status
);
   localparam int JOB_W = $bits(job_type);
   localparam int RSP_W = $bits(rsp_type);

   logic             job_push, job_full, job_empty, job_pop;
   job_type          job_in_data, job_out_data;
   logic [JOB_W-1:0] job_out_bits;
   logic [CAP_W-1:0] bin_capacity;
   logic             res_push, res_full;
   rsp_type          res_in_data, res_out_data;
   logic [RSP_W-1:0] res_out_bits;

   ffbp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_cluster_id   (req_cluster_id),
      .req_record_count (req_record_count),
      .job_push         (job_push),
      .job_data         (job_in_data),
      .job_full         (job_full),
      .bin_capacity     (bin_capacity)
   );

   ffbp_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_job_q (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   (job_in_data),
      .full  (job_full),
      .pop   (job_pop),
      .dout  (job_out_bits),
      .empty (job_empty)
   );
   assign job_out_data = job_out_bits;

   ffbp_back #(.MAX_BINS(MAX_BINS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .bin_capacity (bin_capacity),
      .job_empty    (job_empty),
      .job_data     (job_out_data),
      .job_pop      (job_pop),
      .rsp_full     (res_full),
      .rsp_push     (res_push),
      .rsp_data     (res_in_data)
   );

   ffbp_fifo #(.WIDTH(RSP_W), .DEPTH(2)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (res_in_data),
      .full  (res_full),
      .pop   (rsp_pop),
      .dout  (res_out_bits),
      .empty (rsp_empty)
   );
   assign res_out_data = res_out_bits;

   assign rsp_placed_cluster = res_out_data.cid;
   assign rsp_bin_index      = res_out_data.bin_index;
   assign rsp_bins_open      = res_out_data.bins_open;
   assign rsp_status         = res_out_data.status;

endmodule
`default_nettype wire
